>>> hdl/ntc_adc_to_celsius_macros.svh
// ----------------------------------------------------------------------------
// NTC converter assertion macros
// Concurrent check wrappers that use the clk_i clock and the rst_ni reset.
// ----------------------------------------------------------------------------
`ifndef NTC_ADC_TO_CELSIUS_MACROS_SVH
`define NTC_ADC_TO_CELSIUS_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define NTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ntc converter check failed");
// The expression must never be true outside reset.
`define NTC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("ntc converter forbidden condition seen");
`else
`define NTC_ASSERT(lbl, prop)
`define NTC_ASSERT_NEVER(lbl, expr)
`endif

`endif

>>> hdl/ntc_a2c_pkg.sv
// ----------------------------------------------------------------------------
// NTC converter package
// Fixed-point widths, constants, series coefficients and sideband types.
// ----------------------------------------------------------------------------
`default_nettype none

package ntc_a2c_pkg;

  // Fraction bits of the Q8.24 values.
  localparam int FRAC_W  = 24;
  localparam int AX_W    = 24;  // |x|, below one
  localparam int XX_W    = 24;  // x squared
  localparam int COEF_W  = 25;  // 1/(2k+1), up to one
  localparam int Y_W     = 26;  // Horner accumulator
  localparam int LN_W    = 28;  // |ln a|
  localparam int BETA_W  = 13;
  localparam int N1_W    = 37;  // rounded |ln a| / beta dividend and quotient
  localparam int N2_W    = 39;  // signed reciprocal temperature, Q0.32
  localparam int NUM_W   = 53;  // signed numerator of the Celsius quotient
  localparam int DEN_W   = 43;  // denominator of the Celsius quotient
  localparam int AN_W    = 52;  // numerator magnitude
  localparam int Q2_W    = 11;  // Celsius quotient bits
  localparam int TEMP_W  = 10;

  localparam logic [BETA_W-1:0] BETA_RESET = 13'd3435;
  localparam logic [TEMP_W-1:0] TEMP_MAX   = 10'd1023;

  // 1/298.15 in Q0.32, truncated.
  localparam logic [N2_W-1:0] INV_T25 = 39'd14405390;
  // 20 * 2^32, the scaled one of the Celsius numerator.
  localparam logic signed [NUM_W-1:0] NUM_BIAS = 53'sd85899345920;
  // 20 * 273.15 and the scale of the denominator.
  localparam logic signed [NUM_W-1:0] KELVIN_K = 53'sd5463;
  localparam logic signed [NUM_W-1:0] DEN_K    = 53'sd20;

  // Sideband that travels through the first divider.
  typedef struct packed {
    logic neg;   // x was negative
    logic zc;    // conversion code of zero
  } div1_side_t;

  // Sideband that travels through the second divider.
  typedef struct packed {
    logic zc;
    logic n2z;   // reciprocal temperature is zero
    logic n2n;   // reciprocal temperature is negative
    logic nneg;  // Celsius numerator is negative
    logic ovf;   // quotient does not fit in Q2_W bits
  } div2_side_t;

  // Series coefficient 1/(2k+1) in Q8.24, rounded to nearest.
  function automatic logic [COEF_W-1:0] series_coef(input logic [4:0] k);
    logic [COEF_W-1:0] c;
    unique case (k)
      5'd0:    c = 25'd16777216;
      5'd1:    c = 25'd5592405;
      5'd2:    c = 25'd3355443;
      5'd3:    c = 25'd2396745;
      5'd4:    c = 25'd1864135;
      5'd5:    c = 25'd1525201;
      5'd6:    c = 25'd1290555;
      5'd7:    c = 25'd1118481;
      5'd8:    c = 25'd986895;
      5'd9:    c = 25'd883011;
      5'd10:   c = 25'd798915;
      5'd11:   c = 25'd729444;
      5'd12:   c = 25'd671089;
      5'd13:   c = 25'd621378;
      5'd14:   c = 25'd578525;
      5'd15:   c = 25'd541201;
      5'd16:   c = 25'd508400;
      5'd17:   c = 25'd479349;
      5'd18:   c = 25'd453438;
      5'd19:   c = 25'd430185;
      5'd20:   c = 25'd409200;
      5'd21:   c = 25'd390168;
      5'd22:   c = 25'd372827;
      5'd23:   c = 25'd356962;
      5'd24:   c = 25'd342392;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ntc_a2c_div.sv
// ----------------------------------------------------------------------------
// NTC converter pipelined divider
// Restoring unsigned divider, one quotient bit per register stage. The
// dividend must be below divisor * 2^Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_a2c_div
  import ntc_a2c_pkg::*;
#(
  parameter int N_W    = 37,
  parameter int D_W    = 13,
  parameter int Q_W    = 37,
  parameter int SIDE_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [N_W-1:0]    dividend_i,
  input  logic [D_W-1:0]    divisor_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_valid_o,
  output logic [Q_W-1:0]    quotient_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic [W-1:0]      rem_src [Q_W];
  logic [D_W-1:0]    dvs_src [Q_W];
  logic [Q_W-1:0]    quo_src [Q_W];
  logic [SIDE_W-1:0] side_src[Q_W];
  logic              vld_src [Q_W];

  logic [W-1:0]      rem_d [Q_W];
  logic [Q_W-1:0]    quo_d [Q_W];
  logic [W-1:0]      rem_q [Q_W];
  logic [D_W-1:0]    dvs_q [Q_W];
  logic [Q_W-1:0]    quo_q [Q_W];
  logic [SIDE_W-1:0] side_q[Q_W];
  logic              vld_q [Q_W];

  // Each stage takes its operands from the stage before it.
  always_comb begin
    rem_src[0]  = W'(dividend_i);
    dvs_src[0]  = divisor_i;
    quo_src[0]  = '0;
    side_src[0] = side_i;
    vld_src[0]  = in_valid_i;
    for (int s = 1; s < Q_W; s++) begin
      rem_src[s]  = rem_q[s-1];
      dvs_src[s]  = dvs_q[s-1];
      quo_src[s]  = quo_q[s-1];
      side_src[s] = side_q[s-1];
      vld_src[s]  = vld_q[s-1];
    end
  end

  // One trial subtraction of the shifted divisor per stage.
  always_comb begin
    logic [W-1:0] sh;
    sh = '0;
    for (int s = 0; s < Q_W; s++) begin
      sh       = W'(dvs_src[s]) << (Q_W - 1 - s);
      rem_d[s] = rem_src[s];
      quo_d[s] = quo_src[s];
      if (rem_src[s] >= sh) begin
        rem_d[s] = rem_src[s] - sh;
        quo_d[s][Q_W-1-s] = 1'b1;
      end
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Q_W; s++) vld_q[s] <= 1'b0;
    end else begin
      for (int s = 0; s < Q_W; s++) vld_q[s] <= vld_src[s];
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < Q_W; s++) begin
      rem_q[s]  <= rem_d[s];
      dvs_q[s]  <= dvs_src[s];
      quo_q[s]  <= quo_d[s];
      side_q[s] <= side_src[s];
    end
  end

  assign out_valid_o = vld_q[Q_W-1];
  assign quotient_o  = quo_q[Q_W-1];
  assign side_o      = side_q[Q_W-1];

endmodule

`default_nettype wire

>>> hdl/ntc_adc_to_celsius.sv
// ----------------------------------------------------------------------------
// NTC thermistor ADC code to Celsius converter
// Beta-equation temperature from a divider conversion code, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: raise start with a code on adc_code_i; busy stays low, so the code
// is taken at that edge and a new one may follow in every cycle.
// The result appears on temp_celsius_o and out_of_range_o for one cycle,
// marked by done_o. Throughput is one transaction per cycle. The pipeline
// holds the Horner series, one stage per term, the 37-stage divider by beta
// and the 11-stage Celsius divider, each stage holding one multiplier or one
// trial subtraction. The beta register is written with beta_we_i and
// beta_constant_i; the user must write it only while no transaction is in
// flight, which the block itself does not enforce; it resets to 3435.
// Reset clears all valid bits, so no result is produced for work in flight.
// The receiver cannot stall: results are shown once and never held.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ntc_adc_to_celsius_macros.svh"

module ntc_adc_to_celsius
  import ntc_a2c_pkg::*;
#(
  parameter int ADC_BITS     = 12,
  parameter int SERIES_TERMS = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [11:0]       adc_code_i,
  input  logic              beta_we_i,
  input  logic [BETA_W-1:0] beta_constant_i,
  output logic              done_o,
  output logic [TEMP_W-1:0] temp_celsius_o,
  output logic              out_of_range_o
);

  localparam int EXT_W = ADC_BITS + 12;
  localparam int LAT   = SERIES_TERMS + N1_W + Q2_W + 7;

  // Beta register.
  logic [BETA_W-1:0] beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RESET;
    end else if (beta_we_i) begin
      beta_q <= beta_constant_i;
    end
  end

  // The block never holds off a transaction.
  assign busy = 1'b0;

  // Stage A: |x| = |F - 2c| / F in Q8.24.
  logic [ADC_BITS-1:0] code;
  logic [ADC_BITS:0]   two_c, full, dmag;
  logic                neg_d;
  logic                a_vld_q, a_neg_q, a_zc_q;
  logic [AX_W-1:0]     a_ax_q;

  always_comb begin
    code  = ADC_BITS'(EXT_W'(adc_code_i));
    two_c = {code, 1'b0};
    full  = (ADC_BITS + 1)'(1) << ADC_BITS;
    neg_d = two_c > full;
    dmag  = neg_d ? (two_c - full) : (full - two_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_neg_q <= neg_d;
    a_zc_q  <= (code == '0);
    a_ax_q  <= AX_W'(dmag) << (FRAC_W - ADC_BITS);
  end

  // Stage B: x squared.
  logic [2*AX_W-1:0] sq;
  logic              b_vld_q, b_neg_q, b_zc_q;
  logic [AX_W-1:0]   b_ax_q;
  logic [XX_W-1:0]   b_xx_q;

  assign sq = a_ax_q * a_ax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_neg_q <= a_neg_q;
    b_zc_q  <= a_zc_q;
    b_ax_q  <= a_ax_q;
    b_xx_q  <= sq[2*AX_W-1:FRAC_W];
  end

  // Horner stages: y = 1/(2k+1) + x^2 * y, one term per stage.
  logic [AX_W-1:0] h_ax_src [SERIES_TERMS];
  logic [XX_W-1:0] h_xx_src [SERIES_TERMS];
  logic [Y_W-1:0]  h_y_src  [SERIES_TERMS];
  logic            h_neg_src[SERIES_TERMS];
  logic            h_zc_src [SERIES_TERMS];
  logic            h_vld_src[SERIES_TERMS];
  logic [Y_W-1:0]  h_y_d    [SERIES_TERMS];
  logic [AX_W-1:0] h_ax_q   [SERIES_TERMS];
  logic [XX_W-1:0] h_xx_q   [SERIES_TERMS];
  logic [Y_W-1:0]  h_y_q    [SERIES_TERMS];
  logic            h_neg_q  [SERIES_TERMS];
  logic            h_zc_q   [SERIES_TERMS];
  logic            h_vld_q  [SERIES_TERMS];

  always_comb begin
    h_ax_src[0]  = b_ax_q;
    h_xx_src[0]  = b_xx_q;
    h_y_src[0]   = Y_W'(series_coef(5'(SERIES_TERMS)));
    h_neg_src[0] = b_neg_q;
    h_zc_src[0]  = b_zc_q;
    h_vld_src[0] = b_vld_q;
    for (int j = 1; j < SERIES_TERMS; j++) begin
      h_ax_src[j]  = h_ax_q[j-1];
      h_xx_src[j]  = h_xx_q[j-1];
      h_y_src[j]   = h_y_q[j-1];
      h_neg_src[j] = h_neg_q[j-1];
      h_zc_src[j]  = h_zc_q[j-1];
      h_vld_src[j] = h_vld_q[j-1];
    end
  end

  always_comb begin
    logic [XX_W+Y_W-1:0] prod;
    prod = '0;
    for (int j = 0; j < SERIES_TERMS; j++) begin
      prod     = h_xx_src[j] * h_y_src[j];
      h_y_d[j] = Y_W'(series_coef(5'(SERIES_TERMS - 1 - j)))
               + prod[XX_W+Y_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SERIES_TERMS; j++) h_vld_q[j] <= 1'b0;
    end else begin
      for (int j = 0; j < SERIES_TERMS; j++) h_vld_q[j] <= h_vld_src[j];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < SERIES_TERMS; j++) begin
      h_ax_q[j]  <= h_ax_src[j];
      h_xx_q[j]  <= h_xx_src[j];
      h_y_q[j]   <= h_y_d[j];
      h_neg_q[j] <= h_neg_src[j];
      h_zc_q[j]  <= h_zc_src[j];
    end
  end

  // Stage L: |ln a| = 2|x|y, then the rounded dividend for the beta division.
  logic [AX_W+Y_W-1:0] lnp;
  logic [LN_W-1:0]     lnmag;
  logic                l_vld_q;
  div1_side_t          l_side_q;
  logic [N1_W-1:0]     l_dvd_q;

  assign lnp   = h_ax_q[SERIES_TERMS-1] * h_y_q[SERIES_TERMS-1];
  assign lnmag = LN_W'(lnp >> (FRAC_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_vld_q <= 1'b0;
    end else begin
      l_vld_q <= h_vld_q[SERIES_TERMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    l_side_q.neg <= h_neg_q[SERIES_TERMS-1];
    l_side_q.zc  <= h_zc_q[SERIES_TERMS-1];
    l_dvd_q      <= (N1_W'(lnmag) << 8) + N1_W'(beta_q >> 1);
  end

  // Rounded |ln a| / beta in Q0.32.
  logic            d1_vld;
  logic [N1_W-1:0] d1_quo;
  logic [$bits(div1_side_t)-1:0] d1_side_raw;
  div1_side_t      d1_side;

  ntc_a2c_div #(
    .N_W    (N1_W),
    .D_W    (BETA_W),
    .Q_W    (N1_W),
    .SIDE_W ($bits(div1_side_t))
  ) u_div_beta (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (l_vld_q),
    .dividend_i  (l_dvd_q),
    .divisor_i   (beta_q),
    .side_i      (l_side_q),
    .out_valid_o (d1_vld),
    .quotient_o  (d1_quo),
    .side_o      (d1_side_raw)
  );

  assign d1_side = div1_side_t'(d1_side_raw);

  // Stage N: reciprocal temperature r = 1/298.15 - ln(a)/beta.
  logic                   n_vld_q, n_zc_q;
  logic signed [N2_W-1:0] n_n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else begin
      n_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    n_zc_q <= d1_side.zc;
    n_n2_q <= d1_side.neg ? signed'(INV_T25 + N2_W'(d1_quo))
                          : signed'(INV_T25 - N2_W'(d1_quo));
  end

  // Stage M: Celsius numerator and denominator.
  logic signed [NUM_W-1:0] n2x, num_d, den_full;
  logic                    m_vld_q, m_zc_q, m_n2z_q, m_n2n_q;
  logic signed [NUM_W-1:0] m_num_q;
  logic [DEN_W-1:0]        m_den_q;

  always_comb begin
    n2x      = NUM_W'(n_n2_q);
    num_d    = NUM_BIAS - n2x * KELVIN_K;
    den_full = n2x * DEN_K;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= n_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_zc_q  <= n_zc_q;
    m_n2z_q <= (n_n2_q == '0);
    m_n2n_q <= n_n2_q[N2_W-1];
    m_num_q <= num_d;
    m_den_q <= DEN_W'(den_full);
  end

  // Stage O: numerator magnitude and the range test of the quotient.
  logic                     nneg;
  logic [NUM_W-1:0]         num_abs;
  logic [AN_W-1:0]          anum;
  logic [DEN_W+Q2_W-1:0]    den_top;
  logic                     o_vld_q;
  div2_side_t               o_side_q;
  logic [AN_W-1:0]          o_anum_q;
  logic [DEN_W-1:0]         o_den_q;

  always_comb begin
    nneg    = m_num_q[NUM_W-1];
    num_abs = nneg ? NUM_W'(-m_num_q) : NUM_W'(m_num_q);
    anum    = num_abs[AN_W-1:0];
    den_top = (DEN_W + Q2_W)'(m_den_q) << Q2_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_side_q.zc   <= m_zc_q;
    o_side_q.n2z  <= m_n2z_q;
    o_side_q.n2n  <= m_n2n_q;
    o_side_q.nneg <= nneg;
    o_side_q.ovf  <= (DEN_W + Q2_W)'(anum) >= den_top;
    o_anum_q      <= anum;
    o_den_q       <= m_den_q;
  end

  // Whole-degree quotient.
  logic            d2_vld;
  logic [Q2_W-1:0] d2_quo;
  logic [$bits(div2_side_t)-1:0] d2_side_raw;
  div2_side_t      d2_side;

  ntc_a2c_div #(
    .N_W    (AN_W),
    .D_W    (DEN_W),
    .Q_W    (Q2_W),
    .SIDE_W ($bits(div2_side_t))
  ) u_div_temp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (o_vld_q),
    .dividend_i  (o_anum_q),
    .divisor_i   (o_den_q),
    .side_i      (o_side_q),
    .out_valid_o (d2_vld),
    .quotient_o  (d2_quo),
    .side_o      (d2_side_raw)
  );

  assign d2_side = div2_side_t'(d2_side_raw);

  // Result selection with saturation and the special cases in order.
  logic [TEMP_W-1:0] temp_d;
  logic              oor_d;

  always_comb begin
    temp_d = TEMP_W'(d2_quo);
    oor_d  = 1'b0;
    priority if (d2_side.zc) begin
      temp_d = TEMP_MAX;
      oor_d  = 1'b1;
    end else if (beta_q == '0) begin
      temp_d = '0;
      oor_d  = 1'b1;
    end else if (d2_side.n2z) begin
      temp_d = TEMP_MAX;
      oor_d  = 1'b1;
    end else if (d2_side.n2n) begin
      temp_d = '0;
      oor_d  = 1'b1;
    end else if (d2_side.nneg) begin
      // A value in (-1, 0] truncates to zero and is not clamped.
      temp_d = '0;
      oor_d  = d2_side.ovf || (d2_quo != '0);
    end else if (d2_side.ovf || (d2_quo > Q2_W'(TEMP_MAX))) begin
      temp_d = TEMP_MAX;
      oor_d  = 1'b1;
    end else begin
      temp_d = TEMP_W'(d2_quo);
      oor_d  = 1'b0;
    end
  end

  logic done_q, oor_q;
  logic [TEMP_W-1:0] temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    oor_q  <= oor_d;
  end

  assign done_o         = done_q;
  assign temp_celsius_o = temp_q;
  assign out_of_range_o = oor_q;

  // Checks.
  logic zero_code_acc, zero_code_res;

  assign zero_code_acc = start && !busy && (code == '0);
  assign zero_code_res = done_o && out_of_range_o && (temp_celsius_o == TEMP_MAX);

  `NTC_ASSERT(a_fixed_latency, start && !busy |-> ##LAT done_o)
  `NTC_ASSERT(a_zero_code, zero_code_acc |-> ##LAT zero_code_res)
  `NTC_ASSERT_NEVER(a_zero_beta_flag, done_o && beta_q == '0 && !out_of_range_o)
  `NTC_ASSERT_NEVER(a_clamp_low_flag, d2_vld && d2_side.n2n && !oor_d)

endmodule

`default_nettype wire

>>> bench/ntc_adc_to_celsius_tb.sv
// ----------------------------------------------------------------------------
// NTC converter testbench
// Sends conversion codes under several beta settings and compares each
// Celsius result against a fixed-point beta-equation predictor in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_adc_to_celsius_tb;
  import ntc_a2c_pkg::*;

  localparam int LATENCY = 70;
  localparam int NTERMS  = 15;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    logic              oor;
  } celsius_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [11:0]       adc_code_i = '0;
  logic              beta_we_i = 1'b0;
  logic [BETA_W-1:0] beta_constant_i = '0;
  logic              done_o;
  logic [TEMP_W-1:0] temp_celsius_o;
  logic              out_of_range_o;

  celsius_t          pending_temps[$];
  logic [BETA_W-1:0] beta_now;
  int                errors = 0;

  ntc_adc_to_celsius dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .adc_code_i(adc_code_i), .beta_we_i(beta_we_i),
    .beta_constant_i(beta_constant_i), .done_o(done_o),
    .temp_celsius_o(temp_celsius_o), .out_of_range_o(out_of_range_o)
  );

  always #5 clk_i = ~clk_i;

  // Rounded Q8.24 reciprocal of an odd series index.
  function automatic longint unsigned inv_odd(input longint unsigned n);
    return ((64'd1 << 24) + n / 2) / n;
  endfunction

  // Beta-equation temperature for one code at the given beta.
  function automatic celsius_t predict_celsius(input logic [11:0] code,
                                               input logic [BETA_W-1:0] beta);
    celsius_t r;
    longint unsigned c, d, ax, xx, y, nk, lnmag, n1;
    longint signed n2, num, den, t;
    logic neg;
    c = code;
    if (c == 0) begin
      r.temp = TEMP_MAX; r.oor = 1'b1; return r;
    end
    if (beta == 0) begin
      r.temp = '0; r.oor = 1'b1; return r;
    end
    neg = (2 * c) > 4096;
    d = neg ? (2 * c - 4096) : (4096 - 2 * c);
    ax = (d << 24) >> 12;
    xx = (ax * ax) >> 24;
    nk = 2 * NTERMS + 1;
    y = inv_odd(nk);
    for (int k = NTERMS; k > 0; k--) begin
      nk -= 2;
      y = inv_odd(nk) + ((xx * y) >> 24);
    end
    lnmag = (2 * ax * y) >> 24;
    n1 = (lnmag * 256 + beta / 2) / beta;
    n2 = neg ? (64'sd14405390 + longint'(n1)) : (64'sd14405390 - longint'(n1));
    if (n2 == 0) begin
      r.temp = TEMP_MAX; r.oor = 1'b1; return r;
    end
    if (n2 < 0) begin
      r.temp = '0; r.oor = 1'b1; return r;
    end
    num = 64'sd85899345920 - 5463 * n2;
    den = 20 * n2;
    t = (num >= 0) ? num / den : -((-num) / den);
    if (t < 0) begin
      r.temp = '0; r.oor = 1'b1;
    end else if (t > 1023) begin
      r.temp = TEMP_MAX; r.oor = 1'b1;
    end else begin
      r.temp = t[TEMP_W-1:0]; r.oor = 1'b0;
    end
    return r;
  endfunction

  // Send one code; the transaction is taken at the first edge with busy low.
  task automatic send_code(input logic [11:0] code);
    @(negedge clk_i);
    start = 1'b1;
    adc_code_i = code;
    do @(posedge clk_i); while (busy);
    pending_temps.push_back(predict_celsius(code, beta_now));
  endtask

  // Idle gap after a transaction: mostly none, sometimes short, rarely long.
  task automatic maybe_pause();
    int sel, gap;
    sel = $urandom_range(0, 99);
    if (sel < 60) return;
    gap = (sel < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    @(negedge clk_i);
    start = 1'b0;
    repeat (gap - 1) @(negedge clk_i);
  endtask

  // Wait until every result has arrived and the pipeline has drained.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    wait (pending_temps.size() == 0);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic write_beta(input logic [BETA_W-1:0] value);
    drain();
    beta_we_i = 1'b1;
    beta_constant_i = value;
    @(negedge clk_i);
    beta_we_i = 1'b0;
    beta_now = value;
  endtask

  // Each result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    celsius_t want;
    if (rst_ni && done_o) begin
      if (pending_temps.size() == 0) begin
        $display("%0t: unexpected result temp=%0d oor=%0b", $time,
                 temp_celsius_o, out_of_range_o);
        errors++;
      end else begin
        want = pending_temps.pop_front();
        if (temp_celsius_o !== want.temp) begin
          $display("%0t: temp mismatch expected %0d actual %0d", $time,
                   want.temp, temp_celsius_o);
          errors++;
        end
        if (out_of_range_o !== want.oor) begin
          $display("%0t: range flag mismatch expected %0b actual %0b", $time,
                   want.oor, out_of_range_o);
          errors++;
        end
      end
    end
  end

  // Code extremes, mid-scale and alternating bit patterns at reset beta.
  task automatic test_code_extremes();
    logic [11:0] codes[9] = '{12'd0, 12'd1, 12'd2, 12'd2047, 12'd2048,
                              12'd2049, 12'd4094, 12'd4095, 12'hAAA};
    foreach (codes[i]) send_code(codes[i]);
    send_code(12'h555);
    send_code(12'd20);
  endtask

  // Beta extremes, including zero and all ones, where low beta drives the
  // reciprocal temperature negative and the result clamps.
  task automatic test_beta_extremes();
    logic [BETA_W-1:0] betas[5] = '{13'd1000, 13'd6000, 13'd0, 13'h1FFF, 13'd1};
    foreach (betas[i]) begin
      write_beta(betas[i]);
      send_code(12'd1);
      send_code(12'd4095);
      send_code(12'd300);
    end
  endtask

  // Random codes over several beta settings, with one full pause per phase.
  task automatic test_random();
    logic [11:0] code;
    for (int ph = 0; ph < 6; ph++) begin
      write_beta((ph == 0) ? BETA_RESET : BETA_W'($urandom_range(1000, 6000)));
      for (int i = 0; i < 280; i++) begin
        if ($urandom_range(0, 9) < 8) code = 12'($urandom_range(0, 4095));
        else code = $urandom_range(0, 1) ? 12'($urandom_range(0, 40))
                                         : 12'($urandom_range(4050, 4095));
        send_code(code);
        if (i == 140) drain();
        else if (ph != 2) maybe_pause();
      end
    end
  endtask

  initial begin
    beta_now = BETA_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_code_extremes();
    test_beta_extremes();
    test_random();
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
